[rtl/core/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LenW = 64;
  localparam int KeyW = 32;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [3:0] OpContinue = 4'h0;

  localparam logic [3:0] HdrBase = 4'd2;
  localparam logic [3:0] HdrKeyBytes = 4'd4;
  localparam logic [3:0] HdrExt16Bytes = 4'd2;
  localparam logic [3:0] HdrExt64Bytes = 4'd8;

  typedef enum logic [3:0] {
    PH_BYTE0 = 4'b0001,
    PH_BYTE1 = 4'b0010,
    PH_EXT   = 4'b0100,
    PH_PAY   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] message_type;
    logic [3:0] frame_opcode;
    logic       message_start;
    logic       message_final;
    logic       frame_end;
    logic       empty_frame;
  } result_t;

endpackage

[rtl/core/wsd_parse.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Header decode, length and key capture, and per-byte payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       stream_byte,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               fin_r, fin_nxt;
  logic [3:0]         op_r, op_nxt;
  logic               mask_r, mask_nxt;
  logic [6:0]         code_r, code_nxt;
  logic [3:0]         hcnt_r, hcnt_nxt;
  logic [LenW-1:0]    len_sr_r, len_sr_nxt;
  logic [KeyW-1:0]    key_r, key_nxt;
  logic [LenW-1:0]    rem_r, rem_nxt;
  logic               first_r, first_nxt;
  logic [1:0]         kpos_r, kpos_nxt;
  logic [3:0]         msg_op_r, msg_op_nxt;

  logic [3:0]         len_end;
  logic [3:0]         hdr_size;
  logic               is_len;
  logic [LenW-1:0]    len_shift;
  logic [KeyW-1:0]    key_shift;
  logic [LenW-1:0]    len_fin;
  logic [KeyW-1:0]    key_fin;
  logic [3:0]         msg_op_fin;
  logic               finish;
  logic               last;
  logic [7:0]         key_byte;

  always_comb begin
    len_end = HdrBase;
    if (code_r == LenCode16) begin
      len_end = HdrBase + HdrExt16Bytes;
    end else if (code_r == LenCode64) begin
      len_end = HdrBase + HdrExt64Bytes;
    end
    hdr_size = len_end + (mask_r ? HdrKeyBytes : 4'd0);
    is_len = hcnt_r < len_end;
    len_shift = is_len ? {len_sr_r[LenW-9:0], stream_byte} : len_sr_r;
    key_shift = is_len ? key_r : {key_r[KeyW-9:0], stream_byte};
    if (phase_r == PH_BYTE1) begin
      len_fin = LenW'(stream_byte[6:0]);
      key_fin = '0;
    end else begin
      len_fin = (code_r < LenCode16) ? LenW'(code_r) : len_shift;
      key_fin = mask_r ? key_shift : '0;
    end
    msg_op_fin = (op_r != OpContinue) ? op_r : msg_op_r;
    last = rem_r == LenW'(1);
    case (kpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    fin_nxt = fin_r;
    op_nxt = op_r;
    mask_nxt = mask_r;
    code_nxt = code_r;
    hcnt_nxt = hcnt_r;
    len_sr_nxt = len_sr_r;
    key_nxt = key_r;
    rem_nxt = rem_r;
    first_nxt = first_r;
    kpos_nxt = kpos_r;
    msg_op_nxt = msg_op_r;
    finish = 1'b0;
    res_valid = 1'b0;
    res = '0;
    res.frame_opcode = op_r;
    res.message_type = msg_op_r;
    if (acc) begin
      case (phase_r)
        PH_BYTE0: begin
          fin_nxt = stream_byte[7];
          op_nxt = stream_byte[3:0];
          phase_nxt = PH_BYTE1;
        end
        PH_BYTE1: begin
          mask_nxt = stream_byte[7];
          code_nxt = stream_byte[6:0];
          hcnt_nxt = HdrBase;
          len_sr_nxt = '0;
          key_nxt = '0;
          if (!stream_byte[7] && stream_byte[6:0] < LenCode16) begin
            finish = 1'b1;
          end else begin
            phase_nxt = PH_EXT;
          end
        end
        PH_EXT: begin
          hcnt_nxt = hcnt_r + 4'd1;
          len_sr_nxt = len_shift;
          key_nxt = key_shift;
          finish = hcnt_nxt == hdr_size;
        end
        PH_PAY: begin
          res_valid = 1'b1;
          res.payload_byte = stream_byte ^ key_byte;
          res.message_start = (op_r != OpContinue) && first_r;
          res.message_final = fin_r && last;
          res.frame_end = last;
          rem_nxt = rem_r - LenW'(1);
          first_nxt = 1'b0;
          kpos_nxt = kpos_r + 2'd1;
          if (last) begin
            phase_nxt = PH_BYTE0;
          end
        end
        default: begin
          phase_nxt = PH_BYTE0;
        end
      endcase
      if (finish) begin
        msg_op_nxt = msg_op_fin;
        key_nxt = key_fin;
        rem_nxt = len_fin;
        first_nxt = 1'b1;
        kpos_nxt = 2'd0;
        hcnt_nxt = '0;
        if (len_fin == '0) begin
          phase_nxt = PH_BYTE0;
          res_valid = 1'b1;
          res.message_type = msg_op_fin;
          res.message_start = op_r != OpContinue;
          res.message_final = fin_r;
          res.frame_end = 1'b1;
          res.empty_frame = 1'b1;
        end else begin
          phase_nxt = PH_PAY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BYTE0;
      hcnt_r <= '0;
      rem_r <= '0;
      first_r <= 1'b0;
      kpos_r <= '0;
      msg_op_r <= '0;
      key_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r <= hcnt_nxt;
      rem_r <= rem_nxt;
      first_r <= first_nxt;
      kpos_r <= kpos_nxt;
      msg_op_r <= msg_op_nxt;
      key_r <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    op_r <= op_nxt;
    mask_r <= mask_nxt;
    code_r <= code_nxt;
    len_sr_r <= len_sr_nxt;
  end

  // A frame in its payload phase always has bytes left to deliver.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> rem_r != '0)
    else $error("payload phase with no bytes remaining");

  // Results only come from accepted bytes.
  a_res_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> acc)
    else $error("result without an accepted byte");

  // An empty frame result closes the frame and returns to header parsing.
  a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.empty_frame |-> res.frame_end ##1 phase_r == PH_BYTE0)
    else $error("empty frame did not close the frame");

  // The last payload byte returns the parser to the first header byte.
  a_end_returns: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_end |=> phase_r == PH_BYTE0)
    else $error("frame end did not restart header parsing");

endmodule

[rtl/core/wsd_outbuf.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer output buffer
// Two-entry skid buffer between the parser and the result channel.
// ----------------------------------------------------------------------------
module wsd_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsd_pkg::result_t push_data,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_data
);
  import wsd_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    pop;

  assign pop = out_v_r && out_ready;
  assign can_take = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data = out_d_r;

  always_comb begin
    out_v_nxt = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt = out_d_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  // The skid entry is only ever occupied behind a waiting output word.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid with empty output register");

  // A word pushed while the output stalls lands in the skid entry.
  a_stall_skid: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_v_r && !out_ready |=> skid_v_r)
    else $error("stalled word was not held in the skid entry");

endmodule

[rtl/core/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side framing: strips headers and unmasks payload bytes.
// ----------------------------------------------------------------------------
// The input channel takes one raw stream byte per word on in_stream_byte.
// Header bytes (2 to 14 per frame) produce no result; each payload byte
// produces one result word carrying the unmasked byte, the message and frame
// opcodes, and start, final and frame-end flags. A frame with no payload gives
// one result word marked empty, on the byte that completes its header.
// Results are registered in the output buffer. The block takes one byte every
// cycle while in_ready is high; the parser's state update is a single register
// stage, and the 64-bit length check is one decrement and compare. A two-entry
// output buffer keeps bytes flowing after the receiver stalls until a result
// fills its skid entry; in_ready then drops until the receiver takes a word.
// Header-only bytes are taken whenever the buffer has room.
// Reset clears the parser to await the first header byte of a frame, sets the
// remembered message opcode to zero and empties the output buffer.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic [3:0] out_message_type,
  output logic [3:0] out_frame_opcode,
  output logic       out_message_start,
  output logic       out_message_final,
  output logic       out_frame_end,
  output logic       out_empty_frame
);
  import wsd_pkg::*;

  logic    acc;
  logic    res_valid;
  result_t res;
  result_t out_word;

  assign acc = in_valid && in_ready;

  wsd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .stream_byte (in_stream_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_word)
  );

  assign out_payload_byte  = out_word.payload_byte;
  assign out_message_type  = out_word.message_type;
  assign out_frame_opcode  = out_word.frame_opcode;
  assign out_message_start = out_word.message_start;
  assign out_message_final = out_word.message_final;
  assign out_frame_end     = out_word.frame_end;
  assign out_empty_frame   = out_word.empty_frame;

endmodule

[tb/websocket_frame_deframer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives raw stream bytes into the deframer and checks every result word
// against a cycle-free model of the parser. A short table of hand-built
// frames comes first, then random messages made of fragments, control
// frames and random headers, with idle bursts on both channels, a long
// receiver hold-off and a final frame with the largest 64-bit length.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_test;
  import wsd_pkg::*;

  localparam int unsigned N_ITEMS = 1150;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned HOLD_CYCLES = 40;

  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG = 4'hA;

  localparam int unsigned LK_7 = 0;
  localparam int unsigned LK_16 = 1;
  localparam int unsigned LK_64 = 2;

  localparam int unsigned N_ROWS = 26;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    res;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_stream_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_payload_byte;
  logic [3:0] out_message_type;
  logic [3:0] out_frame_opcode;
  logic       out_message_start;
  logic       out_message_final;
  logic       out_frame_end;
  logic       out_empty_frame;

  result_t expected_words[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  bit bursts_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  bit cur_typed = 1'b0;
  result_t cur_typed_res = '0;

  // Parser state as seen after reset.
  phase_t      frm_phase = PH_BYTE0;
  logic [7:0]  hdr [14] = '{default: 8'h00};
  logic [3:0]  hdr_cnt = '0;
  logic [63:0] pay_len = '0;
  logic [63:0] pay_cnt = '0;
  logic [31:0] mask_word = '0;
  logic [1:0]  key_idx = '0;
  logic [3:0]  msg_op = OpContinue;

  row_t dir_rows [N_ROWS] = '{
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 4'h0, 4'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{8'h81, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h41, 1'b1, '{8'h41, 4'h1, 4'h1, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{8'h02, 1'b0, '0},
    '{8'h81, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 4'h2, 4'h0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{8'h8F, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1, 1'b1}}
  };

  websocket_frame_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_message_type  (out_message_type),
    .out_frame_opcode  (out_frame_opcode),
    .out_message_start (out_message_start),
    .out_message_final (out_message_final),
    .out_frame_end     (out_frame_end),
    .out_empty_frame   (out_empty_frame)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned header_len();
    int unsigned n;
    n = 2 + (hdr[1][7] ? 4 : 0);
    if (hdr[1][6:0] == LenCode16) begin
      n += 2;
    end else if (hdr[1][6:0] == LenCode64) begin
      n += 8;
    end
    return n;
  endfunction

  function automatic result_t make_word(logic [7:0] pb, bit start, bit last, bit empty);
    result_t w;
    w.payload_byte = pb;
    w.message_type = msg_op;
    w.frame_opcode = hdr[0][3:0];
    w.message_start = start;
    w.message_final = hdr[0][7] & last;
    w.frame_end = last;
    w.empty_frame = empty;
    return w;
  endfunction

  function automatic bit close_header(output result_t w);
    logic [6:0] code;
    logic [3:0] op;
    int unsigned k;
    code = hdr[1][6:0];
    op = hdr[0][3:0];
    k = 2;
    if (code < LenCode16) begin
      pay_len = 64'(code);
    end else if (code == LenCode16) begin
      pay_len = {48'd0, hdr[2], hdr[3]};
      k = 4;
    end else begin
      pay_len = {hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7], hdr[8], hdr[9]};
      k = 10;
    end
    mask_word = hdr[1][7] ? {hdr[k], hdr[k + 1], hdr[k + 2], hdr[k + 3]} : 32'd0;
    if (op != OpContinue) msg_op = op;
    pay_cnt = '0;
    key_idx = '0;
    hdr_cnt = '0;
    w = '0;
    if (pay_len == 64'd0) begin
      w = make_word(8'h00, op != OpContinue, 1'b1, 1'b1);
      frm_phase = PH_BYTE0;
      return 1'b1;
    end
    frm_phase = PH_PAY;
    return 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, output bit has, output result_t w);
    logic [7:0] kb;
    bit start;
    bit last;
    has = 1'b0;
    w = '0;
    case (frm_phase)
      PH_BYTE0: begin
        hdr[0] = b;
        hdr_cnt = 4'd1;
        frm_phase = PH_BYTE1;
      end
      PH_BYTE1: begin
        hdr[1] = b;
        hdr_cnt = 4'd2;
        if (header_len() == 2) has = close_header(w);
        else frm_phase = PH_EXT;
      end
      PH_EXT: begin
        hdr[hdr_cnt] = b;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= header_len()) has = close_header(w);
      end
      default: begin
        kb = mask_word[8 * (3 - key_idx) +: 8];
        start = (hdr[0][3:0] != OpContinue) && (pay_cnt == 64'd0);
        last = (pay_cnt + 64'd1) >= pay_len;
        w = make_word(b ^ kb, start, last, 1'b0);
        has = 1'b1;
        key_idx = key_idx + 2'd1;
        pay_cnt = pay_cnt + 64'd1;
        if (last) frm_phase = PH_BYTE0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_word(input result_t got, input result_t want);
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
    if (got.message_type !== want.message_type)
      report_mismatch("message_type", 8'(got.message_type), 8'(want.message_type));
    if (got.frame_opcode !== want.frame_opcode)
      report_mismatch("frame_opcode", 8'(got.frame_opcode), 8'(want.frame_opcode));
    if (got.message_start !== want.message_start)
      report_mismatch("message_start", 8'(got.message_start), 8'(want.message_start));
    if (got.message_final !== want.message_final)
      report_mismatch("message_final", 8'(got.message_final), 8'(want.message_final));
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", 8'(got.frame_end), 8'(want.frame_end));
    if (got.empty_frame !== want.empty_frame)
      report_mismatch("empty_frame", 8'(got.empty_frame), 8'(want.empty_frame));
  endtask

  // Results are checked before the byte taken at the same edge is predicted.
  always @(posedge clk) begin
    result_t got;
    result_t pred;
    bit has;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_payload_byte, out_message_type, out_frame_opcode, out_message_start,
               out_message_final, out_frame_end, out_empty_frame};
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected, payload_byte", got.payload_byte, 8'h00);
        end else begin
          check_word(got, expected_words.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_stream_byte, has, pred);
        if (has) expected_words.push_back(cur_typed ? cur_typed_res : pred);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      int unsigned stall_left;
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t tres = '0);
    int unsigned gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_stream_byte = b;
    cur_typed = typed;
    cur_typed_res = tres;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input bit fin, input logic [2:0] rsv,
                            input bit masked, input int unsigned lkind,
                            input logic [63:0] len, input int unsigned nbytes);
    logic [6:0] code;
    code = (lkind == LK_16) ? LenCode16 : (lkind == LK_64) ? LenCode64 : len[6:0];
    send_byte({fin, rsv, op});
    send_byte({masked, code});
    if (lkind == LK_16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (lkind == LK_64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom));
    repeat (nbytes) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame(input logic [3:0] op, input bit fin);
    int unsigned sel;
    int unsigned lkind;
    int unsigned len;
    logic [2:0] rsv;
    sel = $urandom_range(0, 19);
    rsv = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
    if (sel == 0) begin
      lkind = LK_64;
      len = $urandom_range(0, 20);
    end else if (sel <= 2) begin
      lkind = LK_16;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 40);
    end else begin
      lkind = LK_7;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 8);
    end
    send_frame(op, fin, rsv, 1'($urandom), lkind, 64'(len), len);
  endtask

  initial begin
    int unsigned kind;
    int unsigned nfrag;
    int unsigned frames;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_byte = 8'h00;
    frames = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      send_byte(dir_rows[r].b, dir_rows[r].typed, dir_rows[r].res);
    end

    while (n_sent < N_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        nfrag = $urandom_range(0, 3);
        send_random_frame(($urandom_range(0, 1) == 0) ? OP_TEXT : OP_BIN, nfrag == 0);
        for (int f = 1; f <= nfrag; f++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_random_frame(4'($urandom_range(OP_CLOSE, OP_PONG)), 1'b1);
          end
          send_random_frame(OpContinue, f == nfrag);
        end
      end else if (kind < 9) begin
        send_random_frame(4'($urandom_range(OP_CLOSE, OP_PONG)), 1'b1);
      end else begin
        send_random_frame(4'($urandom), 1'($urandom));
      end
      frames++;
      if (frames == 8 || frames == 30) begin
        hold_req++;
        send_frame(OP_BIN, 1'b1, 3'd0, 1'b1, LK_16, 64'd120, 120);
      end
      if (n_sent + QUIET_TAIL >= N_ITEMS) bursts_on = 1'b0;
    end

    // The largest 64-bit length: the frame never ends within the run.
    send_frame(OP_BIN, 1'b1, 3'd0, 1'b1, LK_64, 64'hFFFF_FFFF_FFFF_FFFF, 20);
    @(negedge clk);
    in_valid = 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("words still expected at end, count", 8'(expected_words.size()), 8'h00);
    end
    if (errors == 0) begin
      $display("websocket_frame_deframer: match");
    end else begin
      $display("websocket_frame_deframer: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("websocket_frame_deframer: mismatch");
    $finish;
  end

endmodule

[websocket_frame_deframer.f]
rtl/core/wsd_pkg.sv
rtl/core/wsd_parse.sv
rtl/core/wsd_outbuf.sv
rtl/core/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
